// File: sv/idmn_pkg.sv
// Shared types and constants for the invariant-division magic number generator.
`default_nettype none

package idmn_pkg;

   localparam int DIVISOR_W  = 31;
   localparam int MULT_W     = 32;
   localparam int SHIFT_W    = 7;
   localparam int EXPO_W     = 5;
   localparam int LOG_W      = 5;
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 32;
   localparam int BOUND_W    = 34;
   localparam int K_W        = 33;
   localparam int DIV_STEPS  = NUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [MULT_W-1:0]  ALL_ONES32 = '1;
   localparam logic [SHIFT_W-1:0] WORD_BITS  = SHIFT_W'(32);

   localparam logic METHOD_SHIFT = 1'b0;
   localparam logic METHOD_ADD   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TZ,
      ST_LOG,
      ST_DIV_TOP,
      ST_DIV_K,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_REDUCE,
      ST_DIV_P2,
      ST_STRIP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quot;
      logic [DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: sv/idmn_divider.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none

module idmn_divider
   import idmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quot_ff, quot_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 take;

   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      take    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], take};
         // a failed trial is below the divisor, so its top bit is clear
         rem_in  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         quot_in = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

// File: sv/invariant_division_magic_number.sv
// Top level: sequencer and datapath of the magic number generator, result register.
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   req     | req_valid, req_ready, req_divisor[30:0]   | in
//   rsp     | rsp_valid, rsp_ready, rsp_method_select,  | out
//           | rsp_magic_multiplier, rsp_shift_count,    |
//           | rsp_bad_divisor                           |
//
// One divisor at a time; req_ready is high only while the sequencer is idle.
// Zero, one and powers of two skip the divider. Other divisors pass through tz, log,
// four or five divides, reduce and strip; the bit-serial 64-step divider dominates.
// Synchronous reset returns the sequencer to idle and empties the result register.
// A finished result waits in the result register while the next divisor is taken.
`default_nettype none

module invariant_division_magic_number
   import idmn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [DIVISOR_W-1:0]      req_divisor,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_method_select,
   output logic [MULT_W-1:0]         rsp_magic_multiplier,
   output logic signed [SHIFT_W-1:0] rsp_shift_count,
   output logic                      rsp_bad_divisor
);

   state_type state_ff, state_in;

   logic [DIVISOR_W-1:0] odd_ff, odd_in;
   logic [EXPO_W-1:0]    expo_ff, expo_in;
   logic [LOG_W-1:0]     s_ff, s_in;
   logic [NUM_W-1:0]     pw_ff, pw_in;
   logic [DEN_W-1:0]     top_ff, top_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [BOUND_W-1:0]   lo_ff, lo_in;
   logic [BOUND_W-1:0]   hi_ff, hi_in;
   logic                 method_ff, method_in;
   logic [MULT_W-1:0]    mult_ff, mult_in;
   logic [SHIFT_W-1:0]   sh_ff, sh_in;
   logic                 bad_ff, bad_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_method_ff, rsp_method_in;
   logic [MULT_W-1:0]    rsp_mult_ff, rsp_mult_in;
   logic [SHIFT_W-1:0]   rsp_sh_ff, rsp_sh_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic req_xfer;
   logic div_state;
   logic reduce_go;
   logic strip_go;
   logic hi_fits;
   logic round_down;
   logic rsp_load;

   idmn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign reduce_go  = (lo_ff[BOUND_W-1:1] < hi_ff[BOUND_W-1:1]) && (s_ff != '0);
   assign strip_go   = (mult_ff != '0) && !mult_ff[0];
   assign hi_fits    = (hi_ff[BOUND_W-1:MULT_W] == '0);
   assign round_down = (div_rsp.rem < (DEN_W'(odd_ff >> 1) + 1'b1));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      div_state = (state_ff == ST_DIV_TOP) || (state_ff == ST_DIV_K) ||
                  (state_ff == ST_DIV_LO) || (state_ff == ST_DIV_HI) ||
                  (state_ff == ST_DIV_P2);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_divisor == '0) ? ST_DONE : ST_TZ;
            end
         end
         ST_TZ: begin
            if (odd_ff[0]) begin
               state_in = (odd_ff == DIVISOR_W'(1)) ? ST_DONE : ST_LOG;
            end
         end
         ST_LOG: begin
            if (mult_ff == '0) begin
               state_in = ST_DIV_TOP;
            end
         end
         ST_DIV_TOP: if (div_rsp.done) state_in = ST_DIV_K;
         ST_DIV_K:   if (div_rsp.done) state_in = ST_DIV_LO;
         ST_DIV_LO:  if (div_rsp.done) state_in = ST_DIV_HI;
         ST_DIV_HI:  if (div_rsp.done) state_in = ST_REDUCE;
         ST_REDUCE: begin
            if (!reduce_go) begin
               state_in = hi_fits ? ST_STRIP : ST_DIV_P2;
            end
         end
         ST_DIV_P2:  if (div_rsp.done) state_in = ST_STRIP;
         ST_STRIP: begin
            if (!strip_go) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and divider control
   always_comb begin
      odd_in        = odd_ff;
      expo_in       = expo_ff;
      s_in          = s_ff;
      pw_in         = pw_ff;
      top_in        = top_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      method_in     = method_ff;
      mult_in       = mult_ff;
      sh_in         = sh_ff;
      bad_in        = bad_ff;
      div_req.start = div_state && !div_rsp.busy && !div_rsp.done;
      div_req.num   = pw_ff;
      div_req.den   = DEN_W'(odd_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               odd_in    = req_divisor;
               expo_in   = '0;
               bad_in    = (req_divisor == '0);
               method_in = METHOD_SHIFT;
               mult_in   = '0;
               sh_in     = '0;
            end
         end
         ST_TZ: begin
            if (!odd_ff[0]) begin
               odd_in  = odd_ff >> 1;
               expo_in = expo_ff + 1'b1;
            end else if (odd_ff == DIVISOR_W'(1)) begin
               if (expo_ff == '0) begin
                  method_in = METHOD_ADD;
                  mult_in   = ALL_ONES32;
                  sh_in     = '0;
               end else begin
                  method_in = METHOD_SHIFT;
                  mult_in   = MULT_W'(1);
                  sh_in     = SHIFT_W'(expo_ff) - WORD_BITS;
               end
            end else begin
               mult_in = MULT_W'(odd_ff);
               s_in    = '0;
            end
         end
         ST_LOG: begin
            // count significant bits of the odd part, mult_ff is scratch here
            if (mult_ff != '0) begin
               mult_in = mult_ff >> 1;
               s_in    = s_ff + 1'b1;
            end else begin
               pw_in = NUM_W'(1) << {1'b1, s_ff};
               sh_in = SHIFT_W'(s_ff) - SHIFT_W'(1);  // shift of the rounded variant
            end
         end
         ST_DIV_TOP: begin
            div_req.num = NUM_W'(ALL_ONES32);
            if (div_rsp.done) begin
               top_in = ALL_ONES32 - div_rsp.rem;
            end
         end
         ST_DIV_K: begin
            div_req.den = top_ff;
            if (div_rsp.done) begin
               k_in = div_rsp.quot[K_W-1:0];
            end
         end
         ST_DIV_LO: begin
            if (div_rsp.done) begin
               lo_in = div_rsp.quot[BOUND_W-1:0];
            end
         end
         ST_DIV_HI: begin
            div_req.num = pw_ff + NUM_W'(k_ff);
            if (div_rsp.done) begin
               hi_in = div_rsp.quot[BOUND_W-1:0];
            end
         end
         ST_REDUCE: begin
            if (reduce_go) begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
               s_in  = s_ff - 1'b1;
            end else if (hi_fits) begin
               method_in = METHOD_SHIFT;
               mult_in   = hi_ff[MULT_W-1:0];
               sh_in     = SHIFT_W'(s_ff);
            end
         end
         ST_DIV_P2: begin
            div_req.num = pw_ff >> 1;
            if (div_rsp.done) begin
               method_in = METHOD_ADD;
               mult_in   = round_down ? div_rsp.quot[MULT_W-1:0]
                                      : div_rsp.quot[MULT_W-1:0] + 1'b1;
            end
         end
         ST_STRIP: begin
            if (strip_go) begin
               mult_in = mult_ff >> 1;
               sh_in   = sh_ff - 1'b1;
            end else begin
               sh_in = sh_ff + SHIFT_W'(expo_ff);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_method_in = rsp_method_ff;
      rsp_mult_in   = rsp_mult_ff;
      rsp_sh_in     = rsp_sh_ff;
      rsp_bad_in    = rsp_bad_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_method_in = method_ff;
         rsp_mult_in   = mult_ff;
         rsp_sh_in     = sh_ff;
         rsp_bad_in    = bad_ff;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      odd_ff        <= odd_in;
      expo_ff       <= expo_in;
      s_ff          <= s_in;
      pw_ff         <= pw_in;
      top_ff        <= top_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      method_ff     <= method_in;
      mult_ff       <= mult_in;
      sh_ff         <= sh_in;
      bad_ff        <= bad_in;
      rsp_method_ff <= rsp_method_in;
      rsp_mult_ff   <= rsp_mult_in;
      rsp_sh_ff     <= rsp_sh_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_method_select    = rsp_method_ff;
   assign rsp_magic_multiplier = rsp_mult_ff;
   assign rsp_shift_count      = $signed(rsp_sh_ff);
   assign rsp_bad_divisor      = rsp_bad_ff;

`ifndef SYNTH
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_divisor |->
         rsp_magic_multiplier == '0 && rsp_shift_count == '0 && !rsp_method_select)
      else $error("bad divisor result carries nonzero fields");

   a_mult_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_divisor |-> rsp_magic_multiplier[0])
      else $error("multiplier left with a trailing zero");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy && div_state)
      else $error("divider started while busy or outside a divide step");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a transfer");
`endif

endmodule

`default_nettype wire

// File: bench/tb_invariant_division_magic_number.sv
// Testbench for the invariant-division magic number generator.
`timescale 1ns / 100ps

module tb_invariant_division_magic_number;
   import idmn_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 2_500_000;

   typedef struct packed {
      logic                      method;
      logic [MULT_W-1:0]         mult;
      logic signed [SHIFT_W-1:0] shift;
      logic                      bad;
   } magic_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [DIVISOR_W-1:0]      req_divisor = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_method_select;
   logic [MULT_W-1:0]         rsp_magic_multiplier;
   logic signed [SHIFT_W-1:0] rsp_shift_count;
   logic                      rsp_bad_divisor;

   magic_result_type magic_expect_q[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               rsp_hold = 0;
   bit               idle_on = 1'b1;

   invariant_division_magic_number dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_divisor          (req_divisor),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_method_select    (rsp_method_select),
      .rsp_magic_multiplier (rsp_magic_multiplier),
      .rsp_shift_count      (rsp_shift_count),
      .rsp_bad_divisor      (rsp_bad_divisor)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Expected method, multiplier and shift for one divisor.
   function automatic magic_result_type predict_magic(input logic [DIVISOR_W-1:0] divisor);
      magic_result_type  r;
      logic [31:0]       odd_part;
      logic [31:0]       probe;
      logic [63:0]       pw, full, top, k, lo, hi, p2, q64;
      logic [31:0]       rem32, mult;
      int                expo, lg, s, sh;
      r = '0;
      if (divisor == '0) begin
         r.bad = 1'b1;
         return r;
      end
      odd_part = {1'b0, divisor};
      expo = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         expo++;
      end
      if (odd_part == 32'd1) begin
         if (expo == 0) begin
            r.method = METHOD_ADD;
            r.mult   = ALL_ONES32;
            r.shift  = '0;
         end else begin
            r.method = METHOD_SHIFT;
            r.mult   = 32'd1;
            r.shift  = SHIFT_W'(expo - 32);
         end
         return r;
      end
      lg = 0;
      probe = odd_part >> 1;
      while (probe != 0) begin
         probe = probe >> 1;
         lg++;
      end
      s    = lg + 1;
      pw   = 64'd1 << (32 + s);
      full = 64'hffff_ffff;
      top  = full - full % {32'd0, odd_part};
      k    = pw / top;
      lo   = pw / {32'd0, odd_part};
      hi   = (pw + k) / {32'd0, odd_part};
      while ((lo >> 1) < (hi >> 1) && s > 0) begin
         lo = lo >> 1;
         hi = hi >> 1;
         s--;
      end
      if (hi[63:32] == 32'd0) begin
         r.method = METHOD_SHIFT;
         mult     = hi[31:0];
         sh       = s;
      end else begin
         // bounds too wide for 32 bits: rounded multiply-add form
         p2       = 64'd1 << (32 + lg);
         q64      = p2 % {32'd0, odd_part};
         rem32    = q64[31:0];
         q64      = p2 / {32'd0, odd_part};
         r.method = METHOD_ADD;
         sh       = lg;
         mult     = (rem32 < (odd_part >> 1) + 32'd1) ? q64[31:0] : q64[31:0] + 32'd1;
      end
      while (mult != 32'd0 && !mult[0]) begin
         mult = mult >> 1;
         sh--;
      end
      r.mult  = mult;
      r.shift = SHIFT_W'(sh + expo);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [DIVISOR_W-1:0] random_divisor();
      logic [DIVISOR_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = DIVISOR_W'(1) << $urandom_range(0, DIVISOR_W - 1);
         1: v = DIVISOR_W'($urandom_range(0, 40));
         2: v = DIVISOR_W'(($urandom | 1) << $urandom_range(1, 12));
         3: v = '1 - DIVISOR_W'($urandom_range(0, 100));
         4: v = DIVISOR_W'($urandom >> $urandom_range(1, 28));
         default: v = DIVISOR_W'($urandom);
      endcase
      return v;
   endfunction

   // Result side: random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checks each result transfer, then queues the prediction for a new request.
   always @(posedge clock) begin
      magic_result_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (magic_expect_q.size() == 0) begin
               $error("result transfer with no divisor outstanding");
               mismatch_count++;
            end else begin
               exp_r = magic_expect_q.pop_front();
               if (rsp_method_select !== exp_r.method) begin
                  $error("method_select: expected %0d, got %0d",
                         exp_r.method, rsp_method_select);
                  mismatch_count++;
               end
               if (rsp_magic_multiplier !== exp_r.mult) begin
                  $error("magic_multiplier: expected %08h, got %08h",
                         exp_r.mult, rsp_magic_multiplier);
                  mismatch_count++;
               end
               if (rsp_shift_count !== exp_r.shift) begin
                  $error("shift_count: expected %0d, got %0d",
                         exp_r.shift, rsp_shift_count);
                  mismatch_count++;
               end
               if (rsp_bad_divisor !== exp_r.bad) begin
                  $error("bad_divisor: expected %0d, got %0d",
                         exp_r.bad, rsp_bad_divisor);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            magic_expect_q.push_back(predict_magic(req_divisor));
      end
   end

   task automatic send_divisor(input logic [DIVISOR_W-1:0] divisor);
      int gap;
      req_valid   <= 1'b1;
      req_divisor <= divisor;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid   <= 1'b0;
         req_divisor <= DIVISOR_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_special_divisors();
      logic [DIVISOR_W-1:0] corner[$];
      idle_on = 1'b1;
      corner = '{31'd0, 31'd1, 31'd2, 31'h4000_0000, 31'd3, 31'd5, 31'd7, 31'd6,
                 31'd10, 31'd12, 31'd25, 31'd641, 31'd125, 31'h7fff_ffff,
                 31'h7fff_fffe, 31'h2aaa_aaaa, 31'h5555_5555, 31'h4000_0001,
                 31'h3fff_ffff, 31'h6000_0000, 31'd1000, 31'd7 << 20};
      foreach (corner[i])
         send_divisor(corner[i]);
   endtask

   task automatic test_random_divisors(input int count);
      idle_on = 1'b1;
      repeat (count)
         send_divisor(random_divisor());
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      repeat (count)
         send_divisor(random_divisor());
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_divisors();
      test_random_divisors(650);
      test_back_to_back(280);
      req_valid <= 1'b0;
      while (magic_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
